### sv/apts_pkg.sv
`timescale 1ns / 1ps

package apts_pkg;

  localparam int APTS_THREADS = 4;

  localparam logic [8:0] TICKS_RESET = 9'd5;
  localparam logic [6:0] WAKE_RESET  = 7'd10;
  localparam logic [7:0] PRIO_SLEEP  = 8'hFE;
  localparam logic [6:0] AGE_MAX     = 7'd127;
  localparam logic [7:0] TIME_RESET  = 8'd1;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_IDLE = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_DELAY  = 3'd1,
    MODE_SELECT = 3'd2,
    MODE_CREATE = 3'd3,
    MODE_EXIT   = 3'd4,
    MODE_YIELD  = 3'd5
  } mode_t;

  typedef enum logic {
    CFG_TICKS = 1'b0,
    CFG_WAKE  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] wake;
  } slot_t;

  typedef struct packed {
    mode_t      mode;
    logic       is_run;
    logic       not_mgr;
    logic       take_free;
    logic [7:0] time_now;
    logic [7:0] delay;
    logic [6:0] wake_prio;
  } ctl_t;

  typedef struct packed {
    logic ready_new;
    logic free_old;
  } flg_t;

endpackage

### sv/apts_in_if.sv
`timescale 1ns / 1ps

interface apts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] delay_ticks;

  modport source (output valid, output mode, output delay_ticks, input ready);
  modport sink (input valid, input mode, input delay_ticks, output ready);
endinterface

### sv/apts_out_if.sv
`timescale 1ns / 1ps

interface apts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] thread;
  logic [7:0] time_now;

  modport source (output valid, output status, output thread, output time_now, input ready);
  modport sink (input valid, input status, input thread, input time_now, output ready);
endinterface

### sv/aging_priority_thread_scheduler_unit.sv
// A request is taken only in the idle state; the scan state then rotates the slot
// ring one slot per cycle past the single update unit, and the done state loads
// the result register once the output is free, so a new request waits for that load.
// Reset (synchronous, active low): all slots free, running slot 0, time 1,
// sub-tick 0, configuration registers at defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module aging_priority_thread_scheduler_unit #(
  parameter int THREADS = apts_pkg::APTS_THREADS
) (
  input  logic       clk,
  input  logic       rst_n,
  apts_in_if.sink    in_ch,
  apts_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata
);

  localparam int RW = $clog2(THREADS);

  apts_pkg::state_t state_r, state_nxt;
  logic [RW-1:0]    cnt_r;
  apts_pkg::mode_t  mode_r;
  logic [7:0]       dt_r;
  logic [RW-1:0]    running_r;
  logic [7:0]       time_r;
  logic [7:0]       sub_r;
  logic [8:0]       tpu_r;
  logic [6:0]       wake_r;

  logic [6:0]       best_r;
  logic [RW-1:0]    sel_r;
  logic             a_found_r;
  logic [RW-1:0]    a_idx_r;
  logic             b_found_r;
  logic [RW-1:0]    b_idx_r;
  logic             free_found_r;
  logic [RW-1:0]    free_idx_r;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [3:0]       out_thread_r;
  logic [7:0]       out_time_r;

  logic             in_rdy;
  logic             shift;
  logic             load;
  logic             in_acc;
  logic             last;

  apts_pkg::slot_t  cell_q [THREADS];
  apts_pkg::slot_t  head_upd;
  apts_pkg::ctl_t   ctl;
  apts_pkg::flg_t   flg;

  logic [8:0]       div9;
  logic             sub_wrap;

  logic [1:0]       res_status;
  logic [RW-1:0]    res_run;

  assign in_acc = in_ch.valid && in_rdy;
  assign last   = (cnt_r == RW'(THREADS - 1));

  genvar gi;
  generate
    for (gi = 0; gi < THREADS; gi++) begin : g_cell
      if (gi == THREADS - 1) begin : g_tail
        apts_cell u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .shift (shift),
          .d     (head_upd),
          .q     (cell_q[gi])
        );
      end else begin : g_mid
        apts_cell u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .shift (shift),
          .d     (cell_q[gi+1]),
          .q     (cell_q[gi])
        );
      end
    end
  endgenerate

  assign ctl.mode      = mode_r;
  assign ctl.is_run    = (cnt_r == running_r);
  assign ctl.not_mgr   = (cnt_r != '0);
  assign ctl.take_free = !free_found_r;
  assign ctl.time_now  = time_r;
  assign ctl.delay     = dt_r;
  assign ctl.wake_prio = wake_r;

  apts_head u_head (
    .cur (cell_q[0]),
    .ctl (ctl),
    .upd (head_upd),
    .flg (flg)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      apts_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = apts_pkg::S_SCAN;
        end
      end
      apts_pkg::S_SCAN: begin
        if (last) begin
          state_nxt = apts_pkg::S_DONE;
        end
      end
      apts_pkg::S_DONE: begin
        if (load) begin
          state_nxt = apts_pkg::S_IDLE;
        end
      end
      default: state_nxt = apts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_rdy = 1'b0;
    shift  = 1'b0;
    load   = 1'b0;
    case (state_r)
      apts_pkg::S_IDLE: in_rdy = 1'b1;
      apts_pkg::S_SCAN: shift = 1'b1;
      apts_pkg::S_DONE: load = !out_valid_r || out_ch.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign div9     = (tpu_r == 9'd0) ? 9'd1 : tpu_r;
  assign sub_wrap = ({1'b0, sub_r} + 9'd1) >= div9;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r  <= apts_pkg::TICKS_RESET;
      wake_r <= apts_pkg::WAKE_RESET;
    end else if (cfg_we) begin
      case (apts_pkg::cfg_idx_t'(cfg_index))
        apts_pkg::CFG_TICKS: tpu_r <= cfg_wdata;
        apts_pkg::CFG_WAKE:  wake_r <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= apts_pkg::TIME_RESET;
      sub_r  <= 8'd0;
    end else if (in_acc && apts_pkg::mode_t'(in_ch.mode) == apts_pkg::MODE_TICK) begin
      if (sub_wrap) begin
        sub_r  <= 8'd0;
        time_r <= time_r + 8'd1;
      end else begin
        sub_r <= sub_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= apts_pkg::mode_t'(in_ch.mode);
      dt_r   <= in_ch.delay_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      best_r       <= 7'd0;
      sel_r        <= '0;
      a_found_r    <= 1'b0;
      a_idx_r      <= '0;
      b_found_r    <= 1'b0;
      b_idx_r      <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
    end else if (in_acc) begin
      cnt_r        <= '0;
      best_r       <= 7'd0;
      sel_r        <= '0;
      a_found_r    <= 1'b0;
      b_found_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else if (shift) begin
      cnt_r <= last ? '0 : cnt_r + RW'(1);
      if (ctl.not_mgr && flg.ready_new && cell_q[0].prio[6:0] > best_r) begin
        best_r <= cell_q[0].prio[6:0];
        sel_r  <= cnt_r;
      end
      if (flg.ready_new && cnt_r > running_r && !a_found_r) begin
        a_found_r <= 1'b1;
        a_idx_r   <= cnt_r;
      end
      if (flg.ready_new && !b_found_r) begin
        b_found_r <= 1'b1;
        b_idx_r   <= cnt_r;
      end
      if (flg.free_old && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cnt_r;
      end
    end
  end

  always_comb begin
    res_status = apts_pkg::STS_OK;
    res_run    = running_r;
    case (mode_r)
      apts_pkg::MODE_TICK: begin
        res_run = '0;
      end
      apts_pkg::MODE_DELAY, apts_pkg::MODE_EXIT, apts_pkg::MODE_YIELD: begin
        if (a_found_r) begin
          res_run = a_idx_r;
        end else if (b_found_r) begin
          res_run = b_idx_r;
        end else begin
          res_run    = '0;
          res_status = apts_pkg::STS_IDLE;
        end
      end
      apts_pkg::MODE_SELECT: begin
        res_run = sel_r;
        if (sel_r == '0) begin
          res_status = apts_pkg::STS_IDLE;
        end
      end
      apts_pkg::MODE_CREATE: begin
        if (!free_found_r) begin
          res_status = apts_pkg::STS_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      running_r   <= res_run;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= res_status;
      out_time_r   <= time_r;
      if (mode_r == apts_pkg::MODE_CREATE) begin
        out_thread_r <= free_found_r ? 4'(free_idx_r) : 4'd0;
      end else begin
        out_thread_r <= 4'(res_run);
      end
    end
  end

  assign in_ch.ready     = in_rdy;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.thread   = out_thread_r;
  assign out_ch.time_now = out_time_r;

endmodule

### sv/apts_cell.sv
`timescale 1ns / 1ps

module apts_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift,
  input  apts_pkg::slot_t d,
  output apts_pkg::slot_t q
);

  logic [7:0] prio_r;
  logic [7:0] wake_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r <= 8'd0;
    end else if (shift) begin
      prio_r <= d.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      wake_r <= d.wake;
    end
  end

  assign q.prio = prio_r;
  assign q.wake = wake_r;

endmodule

### sv/apts_head.sv
`timescale 1ns / 1ps

module apts_head (
  input  apts_pkg::slot_t cur,
  input  apts_pkg::ctl_t  ctl,
  output apts_pkg::slot_t upd,
  output apts_pkg::flg_t  flg
);

  logic       rdy_old;
  logic       free_old;
  logic [6:0] wp_eff;

  assign rdy_old  = (cur.prio != 8'd0) && !cur.prio[7];
  assign free_old = (cur.prio == 8'd0);
  assign wp_eff   = (ctl.wake_prio == 7'd0) ? 7'd1 : ctl.wake_prio;

  always_comb begin
    upd = cur;
    case (ctl.mode)
      apts_pkg::MODE_TICK: begin
        if (ctl.not_mgr) begin
          if (rdy_old) begin
            if (ctl.is_run) begin
              upd.prio = 8'd1;
            end else if (cur.prio[6:0] != apts_pkg::AGE_MAX) begin
              upd.prio = cur.prio + 8'd1;
            end
          end else if (cur.prio == apts_pkg::PRIO_SLEEP && cur.wake == ctl.time_now) begin
            upd.prio = {1'b0, wp_eff};
          end
        end
      end
      apts_pkg::MODE_DELAY: begin
        if (ctl.is_run) begin
          upd.wake = ctl.time_now + ctl.delay;
          upd.prio = apts_pkg::PRIO_SLEEP;
        end
      end
      apts_pkg::MODE_EXIT: begin
        if (ctl.is_run) begin
          upd.prio = 8'd0;
        end
      end
      apts_pkg::MODE_CREATE: begin
        if (ctl.take_free && free_old) begin
          upd.prio = 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign flg.ready_new = (upd.prio != 8'd0) && !upd.prio[7];
  assign flg.free_old  = free_old;

endmodule

### sv/apts_checker.sv
`timescale 1ns / 1ps

module apts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [3:0] out_thread,
  input logic [7:0] out_time
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_thread) && $stable(out_time))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == apts_pkg::STS_OK || out_status == apts_pkg::STS_IDLE ||
      out_status == apts_pkg::STS_FULL))
    else $error("unknown status code");

  a_fail_thread: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == apts_pkg::STS_IDLE || out_status == apts_pkg::STS_FULL)
      |-> out_thread == 4'd0)
    else $error("failed request reports a thread");

endmodule

bind aging_priority_thread_scheduler_unit apts_checker u_apts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_thread (out_ch.thread),
  .out_time   (out_ch.time_now)
);

### tb/sv/aging_priority_thread_scheduler_unit_test.sv
`timescale 1ns / 1ps

module aging_priority_thread_scheduler_unit_test;

  localparam logic [2:0] MODE_RSVD_A = 3'd6;
  localparam logic [2:0] MODE_RSVD_B = 3'd7;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] thread;
    logic [7:0] time_now;
  } sched_result_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [8:0] cfg_wdata;

  apts_in_if  in_if ();
  apts_out_if out_if ();

  aging_priority_thread_scheduler_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  logic [7:0] slot_prio [apts_pkg::APTS_THREADS];
  logic [7:0] slot_wake [apts_pkg::APTS_THREADS];
  int         run_slot;
  logic [7:0] now_time;
  logic [7:0] sub_count;
  logic [8:0] tick_div;
  logic [6:0] wake_lvl;

  sched_result_t pending_results [$];
  int            mismatch_count;
  int            results_seen;
  bit            no_idle;
  bit            hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit prio_ready(input logic [7:0] p);
    return p != 8'd0 && p[7] == 1'b0;
  endfunction

  function automatic logic [1:0] rotate_running();
    int s;
    for (int k = 1; k <= apts_pkg::APTS_THREADS; k++) begin
      s = (run_slot + k) % apts_pkg::APTS_THREADS;
      if (prio_ready(slot_prio[s])) begin
        run_slot = s;
        return apts_pkg::STS_OK;
      end
    end
    run_slot = 0;
    return apts_pkg::STS_IDLE;
  endfunction

  function automatic sched_result_t advance_schedule(input logic [2:0] ev_mode,
                                                     input logic [7:0] ev_delay);
    sched_result_t res;
    logic [1:0]    sts;
    logic [7:0]    best;
    int            div_n;
    int            pick;
    sts = apts_pkg::STS_OK;
    pick = -1;
    case (ev_mode)
      apts_pkg::MODE_TICK: begin
        div_n = (tick_div == 9'd0) ? 1 : int'(tick_div);
        if (int'(sub_count) + 1 >= div_n) sub_count = 8'd0;
        else sub_count = sub_count + 8'd1;
        if (sub_count == 8'd0) now_time = now_time + 8'd1;
        for (int i = 1; i < apts_pkg::APTS_THREADS; i++) begin
          if (prio_ready(slot_prio[i])) begin
            if (i == run_slot) slot_prio[i] = 8'd1;
            else if (slot_prio[i] < {1'b0, apts_pkg::AGE_MAX})
              slot_prio[i] = slot_prio[i] + 8'd1;
          end else if (slot_prio[i] == apts_pkg::PRIO_SLEEP && slot_wake[i] == now_time) begin
            slot_prio[i] = (wake_lvl == 7'd0) ? 8'd1 : {1'b0, wake_lvl};
          end
        end
        run_slot = 0;
      end
      apts_pkg::MODE_DELAY: begin
        slot_wake[run_slot] = now_time + ev_delay;
        slot_prio[run_slot] = apts_pkg::PRIO_SLEEP;
        sts = rotate_running();
      end
      apts_pkg::MODE_SELECT: begin
        best = 8'd0;
        pick = 0;
        for (int i = 1; i < apts_pkg::APTS_THREADS; i++) begin
          if (prio_ready(slot_prio[i]) && slot_prio[i] > best) begin
            best = slot_prio[i];
            pick = i;
          end
        end
        run_slot = pick;
        sts = (pick != 0) ? apts_pkg::STS_OK : apts_pkg::STS_IDLE;
      end
      apts_pkg::MODE_CREATE: begin
        for (int i = 0; i < apts_pkg::APTS_THREADS; i++) begin
          if (slot_prio[i] == 8'd0 && pick < 0) pick = i;
        end
        if (pick < 0) sts = apts_pkg::STS_FULL;
        else slot_prio[pick] = 8'd1;
      end
      apts_pkg::MODE_EXIT: begin
        slot_prio[run_slot] = 8'd0;
        sts = rotate_running();
      end
      apts_pkg::MODE_YIELD: sts = rotate_running();
      default: ;
    endcase
    res.status = sts;
    res.thread = (sts == apts_pkg::STS_IDLE) ? 4'd0 : 4'(run_slot);
    if (ev_mode == apts_pkg::MODE_CREATE) res.thread = (pick < 0) ? 4'd0 : 4'(pick);
    res.time_now = now_time;
    return res;
  endfunction

  task automatic reset_model();
    for (int i = 0; i < apts_pkg::APTS_THREADS; i++) begin
      slot_prio[i] = 8'd0;
      slot_wake[i] = 8'd0;
    end
    run_slot = 0;
    now_time = apts_pkg::TIME_RESET;
    sub_count = 8'd0;
    tick_div = apts_pkg::TICKS_RESET;
    wake_lvl = apts_pkg::WAKE_RESET;
  endtask

  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, 15));
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("mismatch at result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  // keep valid high across back-to-back requests; lower it only for a gap
  task automatic post_event(input logic [2:0] ev_mode, input logic [7:0] ev_delay);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= ev_mode;
    in_if.delay_ticks <= ev_delay;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_results.push_back(advance_schedule(ev_mode, ev_delay));
  endtask

  task automatic post_random_event(input int tick_pct);
    int         roll;
    logic [2:0] ev_mode;
    logic [7:0] ev_delay;
    roll = $urandom_range(0, 99);
    if (roll < tick_pct) begin
      ev_mode = apts_pkg::MODE_TICK;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 22) ev_mode = apts_pkg::MODE_CREATE;
      else if (roll < 42) ev_mode = apts_pkg::MODE_SELECT;
      else if (roll < 58) ev_mode = apts_pkg::MODE_YIELD;
      else if (roll < 74) ev_mode = apts_pkg::MODE_DELAY;
      else if (roll < 92) ev_mode = apts_pkg::MODE_EXIT;
      else if (roll < 96) ev_mode = MODE_RSVD_A;
      else ev_mode = MODE_RSVD_B;
    end
    if ($urandom_range(0, 7) == 0) ev_delay = 8'($urandom_range(0, 255));
    else ev_delay = 8'($urandom_range(1, 4));
    post_event(ev_mode, ev_delay);
  endtask

  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_timing(input logic [8:0] div_val, input logic [8:0] wake_val);
    cfg_we <= 1'b1;
    cfg_index <= apts_pkg::CFG_TICKS;
    cfg_wdata <= div_val;
    @(posedge clk);
    cfg_index <= apts_pkg::CFG_WAKE;
    cfg_wdata <= wake_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_div = div_val;
    wake_lvl = wake_val[6:0];
  endtask

  task automatic test_idle_and_unused();
    post_event(apts_pkg::MODE_SELECT, 8'd0);
    post_event(apts_pkg::MODE_YIELD, 8'd0);
    post_event(MODE_RSVD_A, 8'hFF);
    post_event(MODE_RSVD_B, 8'h00);
  endtask

  task automatic test_create_until_full();
    repeat (apts_pkg::APTS_THREADS + 1) post_event(apts_pkg::MODE_CREATE, 8'h00);
  endtask

  task automatic test_aging_and_sleep();
    post_event(apts_pkg::MODE_SELECT, 8'd0);
    post_event(apts_pkg::MODE_TICK, 8'd0);
    post_event(apts_pkg::MODE_TICK, 8'd0);
    post_event(apts_pkg::MODE_SELECT, 8'd0);
    post_event(apts_pkg::MODE_DELAY, 8'd1);
    post_event(apts_pkg::MODE_YIELD, 8'd0);
    post_event(apts_pkg::MODE_EXIT, 8'd0);
    post_event(apts_pkg::MODE_DELAY, 8'hFF);
    repeat (6) post_event(apts_pkg::MODE_TICK, 8'd0);
    post_event(apts_pkg::MODE_SELECT, 8'd0);
  endtask

  task automatic test_divisor_lowered();
    wait_all_results();
    set_timing(9'd8, 9'd10);
    repeat (5) post_event(apts_pkg::MODE_TICK, 8'd0);
    wait_all_results();
    set_timing(9'd3, 9'd10);
    post_event(apts_pkg::MODE_TICK, 8'd0);
  endtask

  task automatic test_backpressure();
    wait_all_results();
    no_idle = 1'b1;
    hold_req = 1'b1;
    repeat (24) post_random_event(35);
    no_idle = 1'b0;
  endtask

  task automatic run_phase(input logic [8:0] div_val, input logic [8:0] wake_val,
                           input int count, input int tick_pct, input bit burst);
    wait_all_results();
    set_timing(div_val, wake_val);
    no_idle = burst;
    repeat (count) post_random_event(tick_pct);
  endtask

  task automatic test_random_traffic();
    run_phase(9'd1, 9'd1, 150, 35, 1'b0);
    run_phase(9'd256, 9'd127, 100, 40, 1'b0);
    run_phase(9'd0, 9'd0, 150, 35, 1'b1);
    run_phase(9'd3, 9'h1FF, 150, 30, 1'b0);
    run_phase(9'd2, 9'd64, 250, 85, 1'b0);
    run_phase(9'd5, 9'd10, 150, 35, 1'b1);
    run_phase(9'd4, 9'd33, 80, 35, 1'b0);
    no_idle = 1'b0;
  endtask

  initial begin
    int stall;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = draw_wait();
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  initial begin
    sched_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = pending_results.pop_front();
          if (out_if.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d", out_if.status, want.status));
          if (out_if.thread !== want.thread)
            report_mismatch($sformatf("thread got %0d expected %0d", out_if.thread, want.thread));
          if (out_if.time_now !== want.time_now)
            report_mismatch($sformatf("time_now got %0d expected %0d",
                                      out_if.time_now, want.time_now));
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("timeout: nothing moved for %0d cycles", WATCHDOG_CYCLES);
    $display("aging_priority_thread_scheduler_unit_test: FAIL");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= apts_pkg::CFG_TICKS;
    cfg_wdata <= 9'd0;
    in_if.valid <= 1'b0;
    in_if.mode <= apts_pkg::MODE_TICK;
    in_if.delay_ticks <= 8'd0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    mismatch_count = 0;
    results_seen = 0;
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_and_unused();
    test_create_until_full();
    test_aging_and_sleep();
    test_divisor_lowered();
    test_backpressure();
    test_random_traffic();

    wait_all_results();
    repeat (apts_pkg::APTS_THREADS + 12) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("aging_priority_thread_scheduler_unit_test: PASS");
    end else begin
      $display("aging_priority_thread_scheduler_unit_test: FAIL");
    end
    $finish;
  end

endmodule
